/* src/sus_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sus_pkg: shared types and constants of the sorted unique set
// Capacity, field widths, command and status codes, cell control bundle.
// ----------------------------------------------------------------------------
package sus_pkg;

  // number of cells in the chain (at most 63, the largest count that COUNT_W holds)
  localparam int unsigned CAPACITY  = 32;
  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned COUNT_W   = 6;
  // internal fill count wide enough to hold the capacity itself
  localparam int unsigned CNT_W     = $clog2(CAPACITY + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_DUMP   = 2'd2,
    CMD_BAD    = 2'd3
  } sus_cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_DELETED   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4,
    ST_ELEMENT   = 3'd5,
    ST_ERROR     = 3'd6
  } sus_status_e;

  // what every cell does in a cycle
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_ROTATE = 2'd3
  } sus_op_e;

  typedef struct packed {
    sus_op_e op;
  } sus_ctrl_t;

endpackage
`default_nettype wire

/* src/sus_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sus_cell: one storage cell of the sorted chain
// Holds one value and its valid flag, compares against the broadcast key and
// takes data from its left or right neighbour as the chain operation demands.
// ----------------------------------------------------------------------------
module sus_cell (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire sus_pkg::sus_ctrl_t                  ctrl_i,
  input  wire logic signed [sus_pkg::VALUE_W-1:0]  key_i,
  input  wire logic signed [sus_pkg::VALUE_W-1:0]  head_i,
  input  wire logic signed [sus_pkg::VALUE_W-1:0]  left_value_i,
  input  wire logic                                left_valid_i,
  input  wire logic                                left_lt_i,
  input  wire logic signed [sus_pkg::VALUE_W-1:0]  right_value_i,
  input  wire logic                                right_valid_i,
  output logic signed [sus_pkg::VALUE_W-1:0]       value_o,
  output logic                                     valid_o,
  output logic                                     lt_o,
  output logic                                     eq_o
);
  import sus_pkg::*;

  logic signed [VALUE_W-1:0] value_q, value_d;
  logic                      valid_q, valid_d;

  // compare against the key, only a held value takes part
  assign lt_o    = valid_q && (value_q < key_i);
  assign eq_o    = valid_q && (value_q == key_i);
  assign value_o = value_q;
  assign valid_o = valid_q;

  // next value and flag
  always_comb begin
    value_d = value_q;
    valid_d = valid_q;
    case (ctrl_i.op)
      OP_INSERT: begin
        // cells below the key keep, the first other one takes the key,
        // the rest shift up by one
        if (!lt_o) begin
          value_d = left_lt_i ? key_i : left_value_i;
        end
        valid_d = valid_q | left_valid_i;
      end
      OP_DELETE: begin
        // cells from the match on take the right neighbour
        if (!lt_o) begin
          value_d = right_value_i;
        end
        valid_d = right_valid_i;
      end
      OP_ROTATE: begin
        // held values move down, the head wraps round to the last held cell
        value_d = right_valid_i ? right_value_i : head_i;
      end
      default: begin
      end
    endcase
  end

  // value store
  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

endmodule
`default_nettype wire

/* src/sus_chain.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sus_chain: row of cells holding the set in ascending order
// Wires neighbours together, merges the match flags and exposes the head.
// ----------------------------------------------------------------------------
module sus_chain (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire sus_pkg::sus_ctrl_t                  ctrl_i,
  input  wire logic signed [sus_pkg::VALUE_W-1:0]  key_i,
  output logic signed [sus_pkg::VALUE_W-1:0]       head_o,
  output logic                                     found_o,
  output logic [sus_pkg::CAPACITY-1:0]             valid_o
);
  import sus_pkg::*;

  logic signed [VALUE_W-1:0] value_w [CAPACITY];
  logic [CAPACITY-1:0]       valid_w;
  logic [CAPACITY-1:0]       lt_w;
  logic [CAPACITY-1:0]       eq_w;

  assign head_o  = value_w[0];
  assign found_o = |eq_w;
  assign valid_o = valid_w;

  // cells with boundary values at both ends of the row
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VALUE_W-1:0] left_value;
    logic                      left_valid;
    logic                      left_lt;
    logic signed [VALUE_W-1:0] right_value;
    logic                      right_valid;

    if (i == 0) begin : g_first
      assign left_value = '0;
      assign left_valid = 1'b1;
      assign left_lt    = 1'b1;
    end else begin : g_inner_left
      assign left_value = value_w[i-1];
      assign left_valid = valid_w[i-1];
      assign left_lt    = lt_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_value = '0;
      assign right_valid = 1'b0;
    end else begin : g_inner_right
      assign right_value = value_w[i+1];
      assign right_valid = valid_w[i+1];
    end

    sus_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl_i),
      .key_i         (key_i),
      .head_i        (value_w[0]),
      .left_value_i  (left_value),
      .left_valid_i  (left_valid),
      .left_lt_i     (left_lt),
      .right_value_i (right_value),
      .right_valid_i (right_valid),
      .value_o       (value_w[i]),
      .valid_o       (valid_w[i]),
      .lt_o          (lt_w[i]),
      .eq_o          (eq_w[i])
    );
  end

endmodule
`default_nettype wire

/* src/sorted_unique_set.sv */
`timescale 1ns / 1ps
`default_nettype none
// Insert, delete and invalid items: one result, registered in the cycle after the beat;
//   a new item is taken every cycle while the result side keeps up.
// Dump: elements follow from the head cell, one per cycle while the result side keeps up;
//   an empty set gives one empty-flagged result; no item is taken until the dump is out.
// Reset clears every valid flag and the fill count; no clearing pass.
// ----------------------------------------------------------------------------
// sorted_unique_set: ordered set of distinct signed values in a cell chain
// Controls the chain, keeps the fill count and drives the result register.
// ----------------------------------------------------------------------------
module sorted_unique_set (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic [sus_pkg::CMD_W-1:0]           cmd_i,
  input  wire logic signed [sus_pkg::VALUE_W-1:0]  value_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic [sus_pkg::STATUS_W-1:0]             status_o,
  output logic signed [sus_pkg::VALUE_W-1:0]       element_o,
  output logic [sus_pkg::COUNT_W-1:0]              count_o,
  output logic                                     last_o,
  output logic                                     empty_res_o
);
  import sus_pkg::*;

  sus_ctrl_t                 ctrl;
  logic signed [VALUE_W-1:0] head;
  logic                      found;
  logic [CAPACITY-1:0]       cell_valid;

  logic [CNT_W-1:0]          held_q, held_d;
  logic [CNT_W-1:0]          remain_q, remain_d;
  logic                      dump_q, dump_d;
  logic                      out_valid_q, out_valid_d;
  sus_status_e               status_q, status_d;
  logic signed [VALUE_W-1:0] element_q, element_d;
  logic [COUNT_W-1:0]        count_q, count_d;
  logic                      last_q, last_d;
  logic                      empty_q, empty_d;

  logic                      slot_free;
  logic                      accept;

  // handshake
  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = !dump_q && slot_free;
  assign accept     = in_valid_i && in_ready_o;

  sus_chain u_chain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .key_i   (value_i),
    .head_o  (head),
    .found_o (found),
    .valid_o (cell_valid)
  );

  // command decode, fill count and result beat
  always_comb begin
    ctrl.op     = OP_HOLD;
    held_d      = held_q;
    remain_d    = remain_q;
    dump_d      = dump_q;
    out_valid_d = out_valid_q && !out_ready_i;
    status_d    = status_q;
    element_d   = element_q;
    count_d     = count_q;
    last_d      = last_q;
    empty_d     = empty_q;
    if (accept) begin
      out_valid_d = 1'b1;
      element_d   = '0;
      last_d      = 1'b1;
      empty_d     = 1'b0;
      case (sus_cmd_e'(cmd_i))
        CMD_INSERT: begin
          if (found) begin
            status_d = ST_DUPLICATE;
          end else if (held_q == CNT_W'(CAPACITY)) begin
            status_d = ST_FULL;
          end else begin
            ctrl.op  = OP_INSERT;
            held_d   = held_q + CNT_W'(1);
            status_d = ST_INSERTED;
          end
        end
        CMD_DELETE: begin
          if (found) begin
            ctrl.op  = OP_DELETE;
            held_d   = held_q - CNT_W'(1);
            status_d = ST_DELETED;
          end else begin
            status_d = ST_NOT_FOUND;
          end
        end
        CMD_DUMP: begin
          status_d = ST_ELEMENT;
          if (held_q == '0) begin
            empty_d = 1'b1;
          end else begin
            // elements follow from the head cell
            out_valid_d = out_valid_q && !out_ready_i;
            status_d    = status_q;
            element_d   = element_q;
            last_d      = last_q;
            empty_d     = empty_q;
            dump_d      = 1'b1;
            remain_d    = held_q;
          end
        end
        default: begin
          status_d = ST_ERROR;
        end
      endcase
      if (!(dump_d && !dump_q)) begin
        count_d = COUNT_W'(held_d);
      end
    end else if (dump_q && slot_free) begin
      // stream the head and rotate the held values
      ctrl.op     = OP_ROTATE;
      out_valid_d = 1'b1;
      status_d    = ST_ELEMENT;
      element_d   = head;
      count_d     = COUNT_W'(held_q);
      last_d      = (remain_q == CNT_W'(1));
      empty_d     = 1'b0;
      remain_d    = remain_q - CNT_W'(1);
      if (remain_q == CNT_W'(1)) begin
        dump_d = 1'b0;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= '0;
      remain_q    <= '0;
      dump_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      held_q      <= held_d;
      remain_q    <= remain_d;
      dump_q      <= dump_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    status_q  <= status_d;
    element_q <= element_d;
    count_q   <= count_d;
    last_q    <= last_d;
    empty_q   <= empty_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign element_o   = element_q;
  assign count_o     = count_q;
  assign last_o      = last_q;
  assign empty_res_o = empty_q;

`ifndef NO_ASSERTIONS
  // fill count matches the number of held cells
  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(cell_valid) == int'(held_q))
    else $error("fill count differs from held cells");

  // fill count never passes the capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= CNT_W'(CAPACITY))
    else $error("fill count above capacity");

  // a running dump has elements left and takes no new item
  a_dump_remain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dump_q |-> (remain_q != '0) && (remain_q <= held_q) && !in_ready_o)
    else $error("dump bookkeeping broken");

  // the final element of a dump ends dump mode
  a_dump_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dump_q && slot_free && (remain_q == CNT_W'(1))) |=> !dump_q && out_valid_q && last_q)
    else $error("dump did not close on its final element");
`endif

endmodule
`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the sorted unique set
// A driver sends directed and random insert, delete, dump and invalid beats
// from a queue; a shadow copy of the ordered set predicts every result beat,
// and a monitor checks each result field by field against the oldest one.
// ----------------------------------------------------------------------------
module testbench;
  import sus_pkg::*;

  // no idling once this few command beats remain
  localparam int unsigned QUIET_TAIL = 40;

  typedef struct {
    sus_cmd_e                   cmd;
    logic signed [VALUE_W-1:0]  value;
  } cmd_beat_t;

  typedef struct {
    sus_status_e                status;
    logic signed [VALUE_W-1:0]  element;
    logic [COUNT_W-1:0]         count;
    logic                       last;
    logic                       empty;
  } set_result_t;

  logic                        clk_i       = 1'b0;
  logic                        rst_ni      = 1'b0;
  logic                        in_valid_i  = 1'b0;
  logic                        in_ready_o;
  logic [CMD_W-1:0]            cmd_i       = '0;
  logic signed [VALUE_W-1:0]   value_i     = '0;
  logic                        out_valid_o;
  logic                        out_ready_i = 1'b0;
  logic [STATUS_W-1:0]         status_o;
  logic signed [VALUE_W-1:0]   element_o;
  logic [COUNT_W-1:0]          count_o;
  logic                        last_o;
  logic                        empty_res_o;

  cmd_beat_t                   cmd_beats[$];
  set_result_t                 awaited_results[$];
  logic signed [VALUE_W-1:0]   shadow_set[$];
  logic signed [VALUE_W-1:0]   value_pool[$];
  int unsigned                 error_count = 0;
  int unsigned                 send_gap = 0;
  int unsigned                 recv_stall = 0;
  cmd_beat_t                   next_beat;
  set_result_t                 seen;

  sorted_unique_set dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .element_o   (element_o),
    .count_o     (count_o),
    .last_o      (last_o),
    .empty_res_o (empty_res_o)
  );

  always #4 clk_i = ~clk_i;

  // queue one expected result beat
  function automatic void await_result(sus_status_e status, logic signed [VALUE_W-1:0] element,
                                       logic last, logic empty);
    set_result_t r;
    r.status  = status;
    r.element = element;
    r.count   = COUNT_W'(shadow_set.size());
    r.last    = last;
    r.empty   = empty;
    awaited_results.push_back(r);
  endfunction

  // apply one command to the shadow set and queue the results it causes
  function automatic void track_set_op(sus_cmd_e cmd, logic signed [VALUE_W-1:0] value);
    int unsigned pos;
    bit          found;
    pos = 0;
    while (pos < shadow_set.size() && shadow_set[pos] < value) pos++;
    found = (pos < shadow_set.size()) && (shadow_set[pos] == value);
    case (cmd)
      CMD_INSERT: begin
        if (found) begin
          await_result(ST_DUPLICATE, '0, 1'b1, 1'b0);
        end else if (shadow_set.size() >= CAPACITY) begin
          await_result(ST_FULL, '0, 1'b1, 1'b0);
        end else begin
          shadow_set.insert(pos, value);
          await_result(ST_INSERTED, '0, 1'b1, 1'b0);
        end
      end
      CMD_DELETE: begin
        if (found) begin
          shadow_set.delete(pos);
          await_result(ST_DELETED, '0, 1'b1, 1'b0);
        end else begin
          await_result(ST_NOT_FOUND, '0, 1'b1, 1'b0);
        end
      end
      CMD_DUMP: begin
        if (shadow_set.size() == 0) begin
          await_result(ST_ELEMENT, '0, 1'b1, 1'b1);
        end else begin
          foreach (shadow_set[k])
            await_result(ST_ELEMENT, shadow_set[k], k == shadow_set.size() - 1, 1'b0);
        end
      end
      default: begin
        await_result(ST_ERROR, '0, 1'b1, 1'b0);
      end
    endcase
  endfunction

  function automatic void queue_beat(sus_cmd_e cmd, logic signed [VALUE_W-1:0] value);
    cmd_beat_t b;
    b.cmd   = cmd;
    b.value = value;
    cmd_beats.push_back(b);
  endfunction

  // random phase: weights in percent, values mostly drawn from a pool so that
  // deletes hit, duplicates occur and the store fills up
  task automatic queue_phase(int unsigned n, int unsigned ins_w, int unsigned del_w,
                             int unsigned dump_w, int unsigned pool_sz, int unsigned narrow);
    int unsigned                r;
    sus_cmd_e                   cmd;
    logic signed [VALUE_W-1:0]  v;
    if (pool_sz != 0) begin
      value_pool.delete();
      for (int unsigned k = 0; k < pool_sz; k++) begin
        if (narrow != 0) value_pool.push_back($signed($urandom_range(0, 24)) - 12);
        else value_pool.push_back($urandom);
      end
      if (narrow == 0) begin
        value_pool[0] = 32'sh8000_0000;
        value_pool[1] = 32'sh7fff_ffff;
      end
    end
    for (int unsigned k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < ins_w) cmd = CMD_INSERT;
      else if (r < ins_w + del_w) cmd = CMD_DELETE;
      else if (r < ins_w + del_w + dump_w) cmd = CMD_DUMP;
      else cmd = CMD_BAD;
      if ($urandom_range(0, 4) == 0) v = $urandom;
      else v = value_pool[$urandom_range(0, value_pool.size() - 1)];
      queue_beat(cmd, v);
    end
  endtask

  // driver: presents the next command beat, with random bursts of idling
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) track_set_op(sus_cmd_e'(cmd_i), value_i);
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (cmd_beats.size() > 0) begin
          next_beat = cmd_beats.pop_front();
          in_valid_i <= 1'b1;
          cmd_i      <= next_beat.cmd;
          value_i    <= next_beat.value;
          if (cmd_beats.size() > QUIET_TAIL && $urandom_range(0, 3) == 0)
            send_gap = $urandom_range(1, 18);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result side back-pressure in random bursts
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (recv_stall > 0) begin
      recv_stall--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      if (cmd_beats.size() > QUIET_TAIL && $urandom_range(0, 7) == 0)
        recv_stall = $urandom_range(1, 18);
    end
  end

  // monitor: compare each result beat with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_results.size() == 0) begin
        $error("unexpected result beat: status %0d element %0d", status_o, element_o);
        error_count++;
      end else begin
        seen = awaited_results.pop_front();
        if (status_o !== seen.status) begin
          $error("status: expected %0d, got %0d", seen.status, status_o);
          error_count++;
        end
        if (element_o !== seen.element) begin
          $error("element: expected %0d, got %0d", seen.element, element_o);
          error_count++;
        end
        if (count_o !== seen.count) begin
          $error("count: expected %0d, got %0d", seen.count, count_o);
          error_count++;
        end
        if (last_o !== seen.last) begin
          $error("last: expected %0d, got %0d", seen.last, last_o);
          error_count++;
        end
        if (empty_res_o !== seen.empty) begin
          $error("empty_res: expected %0d, got %0d", seen.empty, empty_res_o);
          error_count++;
        end
      end
    end
  end

  // stimulus, reset and end of run
  initial begin
    // directed: empty set, extremes, duplicates, absent deletes, invalid
    queue_beat(CMD_DUMP,   32'sd0);
    queue_beat(CMD_DELETE, 32'sd5);
    queue_beat(CMD_BAD,    32'shffff_ffff);
    queue_beat(CMD_INSERT, 32'sh7fff_ffff);
    queue_beat(CMD_INSERT, 32'sh8000_0000);
    queue_beat(CMD_INSERT, 32'sd0);
    queue_beat(CMD_INSERT, -32'sd1);
    queue_beat(CMD_INSERT, 32'sd1);
    queue_beat(CMD_INSERT, 32'sh8000_0000);
    queue_beat(CMD_DUMP,   32'shffff_ffff);
    queue_beat(CMD_DELETE, 32'sd2);
    queue_beat(CMD_DELETE, 32'sh8000_0000);
    queue_beat(CMD_DELETE, 32'sh7fff_ffff);
    queue_beat(CMD_BAD,    32'sd0);
    queue_beat(CMD_DUMP,   32'sh5555_aaaa);
    queue_beat(CMD_DELETE, 32'sd0);
    queue_beat(CMD_DELETE, -32'sd1);
    queue_beat(CMD_DELETE, 32'sd1);
    queue_beat(CMD_DUMP,   32'sd0);
    queue_beat(CMD_INSERT, 32'sh8000_0001);
    queue_beat(CMD_INSERT, 32'sh7fff_fffe);
    queue_beat(CMD_DUMP,   $urandom);

    // random: fill to full, drain, churn near zero, refill, mixed
    queue_phase(70, 80,  5, 10, 40, 0);
    queue_phase(60, 20, 65, 10,  0, 0);
    queue_phase(60, 45, 45,  8, 12, 1);
    queue_phase(70, 85,  5,  8, 50, 0);
    queue_phase(70, 40, 40, 15,  0, 0);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (cmd_beats.size() != 0 || in_valid_i) @(posedge clk_i);
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (CAPACITY + 8) @(posedge clk_i);

    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10ms;
    $display("Some tests failed");
    $finish;
  end

endmodule

/* sorted_unique_set.f */
src/sus_pkg.sv
src/sus_cell.sv
src/sus_chain.sv
src/sorted_unique_set.sv
tb/testbench.sv
